// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the allocator checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== design/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// types and constants of the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

    // field widths
    localparam int ADDR_W = 21;
    localparam int HDR_W  = 7;

    // default table depth and physical heap size
    localparam int MAX_BLOCKS_DEF = 64;
    localparam longint unsigned HEAP_BYTES = 1048576;

    // heap size as seen through the address width
    localparam logic [ADDR_W-1:0] LIMIT_CAP =
        (HEAP_BYTES >= (64'd1 << ADDR_W)) ? '1 : ADDR_W'(HEAP_BYTES);

    // register reset values
    localparam logic [HDR_W-1:0]  HEADER_RST = 7'd32;
    localparam logic [ADDR_W-1:0] LIMIT_RST  = 21'd1048576;

    // configuration register indexes
    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    // commands
    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_REALLOC = 2'd2
    } t_cmd;

    // result status
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_UNKNOWN = 2'd2
    } t_status;

    // input item
    typedef struct packed {
        t_cmd              command;
        logic [ADDR_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } t_req;

    // result item
    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        t_status           status;
    } t_rsp;

    // one block table entry
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic              free;
    } t_entry;

endpackage

// ===== design/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit heap block allocator over a block table held in one ram
// ----------------------------------------------------------------------------
// One item is taken while busy is low and start is high; its single result
// appears on o_rsp for exactly one cycle with o_done, and must be captured
// then, as the block cannot be held off. The block table lives in a ram read
// one entry per cycle, scanned by an alloc or by an address lookup; a realloc
// that moves its block runs a lookup, then an alloc scan, then frees the old
// block. A free of address zero and an undefined command answer in the
// cycle after they are taken. Configuration may be written at any time the
// block is idle; a new item may start in the cycle its predecessor's result
// is shown.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command channel
    input  logic                        start,
    output logic                        busy,
    input  ffba_pkg::t_req              i_req,
    // result channel
    output logic                        o_done,
    output ffba_pkg::t_rsp              o_rsp,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0] i_cfg_data
);

    localparam int AW     = ffba_pkg::ADDR_W;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int ENT_W  = $bits(ffba_pkg::t_entry);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_FIND,
        S_FREE_OLD
    } t_state;

    t_state                  r_state;
    logic [ffba_pkg::HDR_W-1:0] r_header;
    logic [AW-1:0]           r_limit;
    logic [CNT_W-1:0]        r_count;
    logic [AW-1:0]           r_top;
    logic [1:0]              r_cmd;
    logic [AW-1:0]           r_size;
    logic [AW-1:0]           r_addr;
    logic [CNT_W-1:0]        r_idx;
    logic                    r_vld;
    logic [IDX_W-1:0]        r_ridx;
    logic                    r_free_old;
    logic [IDX_W-1:0]        r_old_idx;
    logic [AW-1:0]           r_old_start;
    logic [AW-1:0]           r_old_size;
    logic                    r_done;
    ffba_pkg::t_rsp          r_rsp;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    ffba_pkg::t_entry        ram_wdata;
    logic                    ram_re;
    logic [ENT_W-1:0]        ram_rdata;
    ffba_pkg::t_entry        rd;

    logic [AW:0]             sum_hdr;
    logic                    find_hit;
    logic                    alloc_hit;
    logic                    scan_end;
    logic [AW-1:0]           limit_eff;
    logic [AW+1:0]           new_top;
    logic                    fits;
    logic                    full;
    logic [AW:0]             top_hdr;

    // block table
    ffba_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd = ffba_pkg::t_entry'(ram_rdata);

    // scan issue: one entry read per cycle while entries remain
    assign ram_re = ((r_state == S_ALLOC) || (r_state == S_FIND)) && (r_idx < r_count);

    // per-entry tests on the entry read last cycle
    assign sum_hdr   = {1'b0, rd.start} + (AW+1)'(r_header);
    assign find_hit  = r_vld && (sum_hdr == {1'b0, r_addr});
    assign alloc_hit = r_vld && rd.free && (rd.size >= r_size);
    assign scan_end  = !r_vld && !(r_idx < r_count);

    // append check for a new block at the heap top
    assign limit_eff = (r_limit < ffba_pkg::LIMIT_CAP) ? r_limit : ffba_pkg::LIMIT_CAP;
    assign new_top   = {2'b00, r_top} + (AW+2)'(r_header) + (AW+2)'(r_size);
    assign fits      = new_top <= {2'b00, limit_eff};
    assign full      = r_count >= CNT_FULL;
    assign top_hdr   = {1'b0, r_top} + (AW+1)'(r_header);

    // table write: mark used, append, or mark free
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ridx;
        ram_wdata = rd;
        unique case (r_state)
            S_ALLOC: begin
                if (alloc_hit) begin
                    ram_we         = 1'b1;
                    ram_wdata.free = 1'b0;
                end else if (scan_end && !full && fits) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_count[IDX_W-1:0];
                    ram_wdata = '{start: r_top, size: r_size, free: 1'b0};
                end
            end
            S_FIND: begin
                if (find_hit && ((r_cmd == ffba_pkg::CMD_FREE) || (r_size == '0))) begin
                    ram_we         = 1'b1;
                    ram_wdata.free = 1'b1;
                end
            end
            S_FREE_OLD: begin
                ram_we    = 1'b1;
                ram_waddr = r_old_idx;
                ram_wdata = '{start: r_old_start, size: r_old_size, free: 1'b1};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_header   <= ffba_pkg::HEADER_RST;
            r_limit    <= ffba_pkg::LIMIT_RST;
            r_count    <= '0;
            r_top      <= '0;
            r_vld      <= 1'b0;
            r_idx      <= '0;
            r_free_old <= 1'b0;
        end else begin
            r_done <= 1'b0;

            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ffba_pkg::REG_HEADER: r_header <= i_cfg_data[ffba_pkg::HDR_W-1:0];
                    ffba_pkg::REG_LIMIT:  r_limit  <= i_cfg_data;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd      <= i_req.command;
                        r_size     <= i_req.request_size;
                        r_addr     <= i_req.block_address;
                        r_idx      <= '0;
                        r_vld      <= 1'b0;
                        r_free_old <= 1'b0;
                        unique case (i_req.command)
                            ffba_pkg::CMD_ALLOC: begin
                                r_state <= S_ALLOC;
                            end
                            ffba_pkg::CMD_FREE,
                            ffba_pkg::CMD_REALLOC: begin
                                if (i_req.block_address == '0) begin
                                    if (i_req.command == ffba_pkg::CMD_FREE) begin
                                        r_rsp  <= '{result_address: '0,
                                                    status: ffba_pkg::ST_DONE};
                                        r_done <= 1'b1;
                                    end else begin
                                        r_state <= S_ALLOC;
                                    end
                                end else begin
                                    r_state <= S_FIND;
                                end
                            end
                            default: begin
                                // undefined command answers done
                                r_rsp  <= '{result_address: '0, status: ffba_pkg::ST_DONE};
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end

                S_ALLOC: begin
                    r_vld  <= ram_re;
                    r_ridx <= r_idx[IDX_W-1:0];
                    if (ram_re) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (alloc_hit) begin
                        // reuse first free block that is big enough
                        r_rsp   <= '{result_address: sum_hdr[AW-1:0],
                                     status: ffba_pkg::ST_DONE};
                        r_done  <= !r_free_old;
                        r_state <= r_free_old ? S_FREE_OLD : S_IDLE;
                    end else if (scan_end) begin
                        if (full || !fits) begin
                            r_rsp   <= '{result_address: '0, status: ffba_pkg::ST_NOMEM};
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            // append a new block at the heap top
                            r_count <= r_count + 1'b1;
                            r_top   <= new_top[AW-1:0];
                            r_rsp   <= '{result_address: top_hdr[AW-1:0],
                                         status: ffba_pkg::ST_DONE};
                            r_done  <= !r_free_old;
                            r_state <= r_free_old ? S_FREE_OLD : S_IDLE;
                        end
                    end
                end

                S_FIND: begin
                    r_vld  <= ram_re;
                    r_ridx <= r_idx[IDX_W-1:0];
                    if (ram_re) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (find_hit) begin
                        if ((r_cmd == ffba_pkg::CMD_FREE) || (r_size == '0)) begin
                            r_rsp   <= '{result_address: '0, status: ffba_pkg::ST_DONE};
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (rd.size >= r_size) begin
                            // block already big enough, keep it
                            r_rsp   <= '{result_address: r_addr, status: ffba_pkg::ST_DONE};
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            // move: allocate anew, then free the old block
                            r_old_idx   <= r_ridx;
                            r_old_start <= rd.start;
                            r_old_size  <= rd.size;
                            r_free_old  <= 1'b1;
                            r_idx       <= '0;
                            r_vld       <= 1'b0;
                            r_state     <= S_ALLOC;
                        end
                    end else if (scan_end) begin
                        r_rsp   <= '{result_address: '0, status: ffba_pkg::ST_UNKNOWN};
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end

                S_FREE_OLD: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== design/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// ffba_checker
// port-level checks of the allocator command and result channels
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffba_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           busy,
    input  logic           o_done,
    input  ffba_pkg::t_rsp o_rsp
);

    // a result only follows work or an item taken the cycle before
    `ASSERT_CLK(a_done_has_cause, i_clk, i_rst_n, o_done |-> $past(busy || start), "result without an item")

    // an accepted item starts work or answers at once
    `ASSERT_CLK(a_accept_progress, i_clk, i_rst_n, (start && !busy) |=> (busy || o_done), "item accepted but nothing happens")

    // end of work always shows a result
    `ASSERT_CLK(a_end_gives_result, i_clk, i_rst_n, ($fell(busy) && $past(i_rst_n)) |-> o_done, "work ended without a result")

    // a failed request never grants an address
    `ASSERT_NEVER(a_fail_zero_addr, i_clk, i_rst_n, o_done && (o_rsp.status != ffba_pkg::ST_DONE) && (o_rsp.result_address != '0), "failure with nonzero address")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
